// File: hw/rtl/cooperative_task_scheduler_defines.svh
// assertion macros used by the scheduler engine
// expects aclk and aresetn in the scope of each use
`ifndef COOPERATIVE_TASK_SCHEDULER_DEFINES_SVH
`define COOPERATIVE_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cts_pkg.sv
// types, constants and helpers for the cooperative task scheduler
// no dependencies
`default_nettype none

package cts_pkg;

    localparam int NUM_SLOTS       = 8;
    localparam int RUN_COUNT_WIDTH = 8;
    localparam int TIME_WIDTH      = 32;
    localparam int RESULTS_CAP     = 8;

    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int RES_CNT_W  = $clog2(RESULTS_CAP);

    localparam logic [1:0] FUNC_ADD      = 2'd0;
    localparam logic [1:0] FUNC_TICK     = 2'd1;
    localparam logic [1:0] FUNC_DISPATCH = 2'd2;

    localparam logic [1:0] KIND_ADD_ACK = 2'd0;
    localparam logic [1:0] KIND_TASK    = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [NUM_SLOTS-1:0]  slot_vec_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] task_id;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [15:0] task_out;
        logic        table_full;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic [15:0]                task_id;
        logic [TIME_WIDTH-1:0]      delay;
        logic [TIME_WIDTH-1:0]      period;
        logic [RUN_COUNT_WIDTH-1:0] runs;
    } slot_entry_t;

    typedef struct packed {
        logic      en;
        slot_idx_t addr;
    } mem_rd_t;

    typedef struct packed {
        logic        en;
        slot_idx_t   addr;
        slot_entry_t data;
    } mem_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DSP_FIND,
        ST_DSP_DATA,
        ST_RESP
    } state_t;

    // low three bits of a slot number
    function automatic logic [2:0] slot_field(input slot_idx_t idx);
        logic [7:0] w;
        w = 8'(idx);
        return w[2:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cts_slot_ram.sv
// slot table memory: one write port, one read port with registered data
// depends on cts_pkg
`default_nettype none

module cts_slot_ram (
    input  wire logic                 aclk,
    input  wire cts_pkg::mem_rd_t     rd,
    input  wire cts_pkg::mem_wr_t     wr,
    output cts_pkg::slot_entry_t      rd_data
);
    import cts_pkg::*;

    slot_entry_t entries_reg [NUM_SLOTS];
    slot_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entries_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata_reg <= entries_reg[rd.addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cts_out_buf.sv
// one-entry output register between the engine and the result channel
// depends on cts_pkg
`default_nettype none

module cts_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cts_pkg::out_beat_t  in_beat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cts_pkg::out_beat_t       out_beat
);
    import cts_pkg::*;

    logic      vld_reg;
    out_beat_t data_reg;

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_beat;
        end
    end

    assign out_valid = vld_reg;
    assign out_beat  = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cts_engine.sv
// scheduler sequencer: valid and ready bits, read-modify-write of the slot memory
// depends on cts_pkg and cooperative_task_scheduler_defines.svh
`default_nettype none
`include "cooperative_task_scheduler_defines.svh"

module cts_engine (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cts_pkg::in_beat_t     in_beat,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output cts_pkg::out_beat_t         res_beat,
    output cts_pkg::mem_rd_t           mem_rd,
    output cts_pkg::mem_wr_t           mem_wr,
    input  wire cts_pkg::slot_entry_t  mem_rdata
);
    import cts_pkg::*;

    state_t                state_reg, state_next;
    slot_vec_t             valid_reg, valid_next;
    slot_vec_t             ready_reg, ready_next;
    logic [SLOT_CNT_W-1:0] issue_reg, issue_next;
    logic                  wb_vld_reg, wb_vld_next;
    slot_idx_t             wb_idx_reg, wb_idx_next;
    slot_idx_t             scan_reg, scan_next;
    slot_idx_t             cur_reg, cur_next;
    logic [RES_CNT_W-1:0]  nres_reg, nres_next;
    out_beat_t             res_reg, res_next;

    logic                  free_found;
    slot_idx_t             free_idx;
    logic                  rdy_found;
    slot_idx_t             rdy_idx;
    logic                  more_above;
    logic [TIME_WIDTH-1:0] dly_in;
    logic [TIME_WIDTH-1:0] per_in;
    slot_entry_t           tick_ent;
    slot_entry_t           dsp_ent;
    logic                  dsp_last;

    assign dly_in = in_beat.start_delay[TIME_WIDTH-1:0];
    assign per_in = in_beat.repeat_period[TIME_WIDTH-1:0];

    // lowest free slot, next ready slot from scan point, ready slots above current
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        rdy_found  = 1'b0;
        rdy_idx    = '0;
        more_above = 1'b0;
        for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
            if (!valid_reg[j]) begin
                free_found = 1'b1;
                free_idx   = slot_idx_t'(j);
            end
            if (ready_reg[j] && (j >= int'(scan_reg))) begin
                rdy_found = 1'b1;
                rdy_idx   = slot_idx_t'(j);
            end
            if (ready_reg[j] && (j > int'(cur_reg))) begin
                more_above = 1'b1;
            end
        end
    end

    // tick update of one entry
    always_comb begin
        tick_ent = mem_rdata;
        if (mem_rdata.delay == '0) begin
            tick_ent.delay = mem_rdata.period;
            if (mem_rdata.runs != '1) begin
                tick_ent.runs = mem_rdata.runs + 1'b1;
            end
        end else begin
            tick_ent.delay = mem_rdata.delay - 1'b1;
        end
    end

    always_comb begin
        dsp_ent      = mem_rdata;
        dsp_ent.runs = mem_rdata.runs - 1'b1;
        dsp_last     = !more_above || (nres_reg == RES_CNT_W'(RESULTS_CAP - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            ready_reg  <= '0;
            wb_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            ready_reg  <= ready_next;
            wb_vld_reg <= wb_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg  <= issue_next;
        wb_idx_reg <= wb_idx_next;
        scan_reg   <= scan_next;
        cur_reg    <= cur_next;
        nres_reg   <= nres_next;
        res_reg    <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        ready_next  = ready_reg;
        issue_next  = issue_reg;
        wb_vld_next = wb_vld_reg;
        wb_idx_next = wb_idx_reg;
        scan_next   = scan_reg;
        cur_next    = cur_reg;
        nres_next   = nres_reg;
        res_next    = res_reg;
        mem_rd      = '0;
        mem_wr      = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res_beat    = res_reg;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    unique case (in_beat.func)
                        FUNC_ADD: begin
                            if (free_found) begin
                                mem_wr.en           = 1'b1;
                                mem_wr.addr         = free_idx;
                                mem_wr.data.task_id = in_beat.task_id;
                                mem_wr.data.delay   = dly_in;
                                mem_wr.data.period  = per_in;
                                mem_wr.data.runs    =
                                    RUN_COUNT_WIDTH'((dly_in == '0) && (per_in == '0));
                                valid_next[free_idx] = 1'b1;
                                ready_next[free_idx] = (dly_in == '0) && (per_in == '0);
                                res_next = '{kind: KIND_ADD_ACK, slot: slot_field(free_idx),
                                             task_out: '0, table_full: 1'b0, last: 1'b1};
                            end else begin
                                res_next = '{kind: KIND_ADD_ACK, slot: '0, task_out: '0,
                                             table_full: 1'b1, last: 1'b1};
                            end
                            state_next = ST_RESP;
                        end
                        FUNC_TICK: begin
                            issue_next  = '0;
                            wb_vld_next = 1'b0;
                            state_next  = ST_TICK;
                        end
                        FUNC_DISPATCH: begin
                            scan_next  = '0;
                            nres_next  = '0;
                            state_next = ST_DSP_FIND;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // read slot n while slot n-1 is written back
                if (issue_reg < SLOT_CNT_W'(NUM_SLOTS)) begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = issue_reg[SLOT_IDX_W-1:0];
                    issue_next  = issue_reg + 1'b1;
                    wb_vld_next = 1'b1;
                    wb_idx_next = issue_reg[SLOT_IDX_W-1:0];
                end else begin
                    wb_vld_next = 1'b0;
                end
                if (wb_vld_reg && valid_reg[wb_idx_reg]) begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = wb_idx_reg;
                    mem_wr.data = tick_ent;
                    ready_next[wb_idx_reg] = (tick_ent.runs != '0);
                end
                if ((issue_reg == SLOT_CNT_W'(NUM_SLOTS)) && !wb_vld_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DSP_FIND: begin
                if (rdy_found) begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = rdy_idx;
                    cur_next    = rdy_idx;
                    state_next  = ST_DSP_DATA;
                end else begin
                    res_next = '{kind: KIND_NONE, slot: '0, task_out: '0,
                                 table_full: 1'b0, last: 1'b1};
                    state_next = ST_RESP;
                end
            end
            ST_DSP_DATA: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cur_reg;
                mem_wr.data = dsp_ent;
                if (mem_rdata.period == '0) begin
                    valid_next[cur_reg] = 1'b0;
                    ready_next[cur_reg] = 1'b0;
                end else begin
                    ready_next[cur_reg] = (dsp_ent.runs != '0);
                end
                res_next = '{kind: KIND_TASK, slot: slot_field(cur_reg),
                             task_out: mem_rdata.task_id, table_full: 1'b0, last: dsp_last};
                nres_next  = nres_reg + 1'b1;
                scan_next  = cur_reg + 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = res_reg.last ? ST_IDLE : ST_DSP_FIND;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CTS_ASSERT_NOW(a_no_rw_same_slot, mem_rd.en && mem_wr.en, mem_rd.addr != mem_wr.addr, "read and write hit the same slot")
    `CTS_ASSERT_NOW(a_ready_implies_valid, 1'b1, (ready_reg & ~valid_reg) == '0, "ready bit on a free slot")
    `CTS_ASSERT_NOW(a_dispatch_has_runs, state_reg == ST_DSP_DATA, mem_rdata.runs != '0, "dispatched slot without pending runs")
    `CTS_ASSERT_NOW(a_none_is_last, res_valid && (res_beat.kind == KIND_NONE), res_beat.last, "none result not marked last")
    `CTS_ASSERT_NEXT(a_tick_starts_walk, in_valid && in_ready && (in_beat.func == FUNC_TICK), state_reg == ST_TICK, "tick did not start the slot walk")

endmodule

`default_nettype wire

// File: hw/rtl/cooperative_task_scheduler.sv
// cooperative task scheduler: slot table in a memory with registered read data, one item at a time
// add: one result per input beat; tick: no result
// dispatch: a none result if no slot is ready, else one result per dispatched task, each through
// the find, read and emit steps, and then through the output register
// reset clears the valid and ready bits; the memory needs no clearing pass
// depends on cts_pkg, cts_slot_ram, cts_engine, cts_out_buf
`default_nettype none

module cooperative_task_scheduler (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cts_pkg::in_beat_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cts_pkg::out_beat_t       m_data
);
    import cts_pkg::*;

    mem_rd_t     mem_rd;
    mem_wr_t     mem_wr;
    slot_entry_t mem_rdata;
    logic        res_valid;
    logic        res_ready;
    out_beat_t   res_beat;

    cts_slot_ram u_ram (
        .aclk    (aclk),
        .rd      (mem_rd),
        .wr      (mem_wr),
        .rd_data (mem_rdata)
    );

    cts_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat),
        .mem_rd    (mem_rd),
        .mem_wr    (mem_wr),
        .mem_rdata (mem_rdata)
    );

    cts_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_beat   (res_beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (m_data)
    );

endmodule

`default_nettype wire

// File: tb/tb_cooperative_task_scheduler.sv
// self-checking testbench for cooperative_task_scheduler: directed and random beats with
// random stalls on both channels, results checked against an in-bench slot table predictor
// depends on cts_pkg and the cooperative_task_scheduler rtl
`default_nettype none

module tb_cooperative_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [RUN_COUNT_WIDTH-1:0] RUNS_MAX = '1;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    cooperative_task_scheduler u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted slot table
    bit                       tbl_valid  [NUM_SLOTS] = '{default: 1'b0};
    bit [15:0]                tbl_task   [NUM_SLOTS] = '{default: '0};
    bit [TIME_WIDTH-1:0]      tbl_delay  [NUM_SLOTS] = '{default: '0};
    bit [TIME_WIDTH-1:0]      tbl_period [NUM_SLOTS] = '{default: '0};
    bit [RUN_COUNT_WIDTH-1:0] tbl_runs   [NUM_SLOTS] = '{default: '0};

    in_beat_t  pending_items[$];
    out_beat_t sched_results[$];

    int fail_count = 0;
    int n_adds = 0, n_ticks = 0, n_dispatches = 0, n_ignored = 0;
    int n_results = 0, n_full = 0, n_tasks = 0, n_saturated = 0;

    bit in_taken = 1'b0, rx_taken = 1'b0;
    bit tx_quiet = 1'b0, rx_quiet = 1'b0;
    int in_gap = 0, rx_stall = 0;

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic in_beat_t mk_item(input logic [1:0] f, input logic [15:0] id,
                                         input logic [31:0] dly, input logic [31:0] per);
        in_beat_t b;
        b.func          = f;
        b.task_id       = id;
        b.start_delay   = dly;
        b.repeat_period = per;
        return b;
    endfunction

    function automatic void sched_step(input in_beat_t b);
        out_beat_t r;
        bit        placed;
        int        n;
        placed = 1'b0;
        n      = 0;
        case (b.func)
            FUNC_ADD: begin
                n_adds++;
                r      = '0;
                r.kind = KIND_ADD_ACK;
                r.last = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!placed && !tbl_valid[i]) begin
                        placed        = 1'b1;
                        tbl_valid[i]  = 1'b1;
                        tbl_task[i]   = b.task_id;
                        tbl_delay[i]  = b.start_delay[TIME_WIDTH-1:0];
                        tbl_period[i] = b.repeat_period[TIME_WIDTH-1:0];
                        tbl_runs[i]   = RUN_COUNT_WIDTH'(
                            (tbl_delay[i] == 0 && tbl_period[i] == 0) ? 1 : 0);
                        r.slot        = 3'(i);
                    end
                end
                if (!placed) begin
                    r.table_full = 1'b1;
                    n_full++;
                end
                sched_results.push_back(r);
            end
            FUNC_TICK: begin
                n_ticks++;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_delay[i] == 0) begin
                            tbl_delay[i] = tbl_period[i];
                            if (tbl_runs[i] != RUNS_MAX) begin
                                tbl_runs[i]++;
                            end else begin
                                n_saturated++;
                            end
                        end else begin
                            tbl_delay[i]--;
                        end
                    end
                end
            end
            FUNC_DISPATCH: begin
                n_dispatches++;
                for (int i = 0; i < NUM_SLOTS && n < RESULTS_CAP; i++) begin
                    if (tbl_valid[i] && tbl_runs[i] != 0) begin
                        tbl_runs[i]--;
                        r          = '0;
                        r.kind     = KIND_TASK;
                        r.slot     = 3'(i);
                        r.task_out = tbl_task[i];
                        sched_results.push_back(r);
                        n++;
                        n_tasks++;
                        if (tbl_period[i] == 0) begin
                            tbl_valid[i] = 1'b0;
                        end
                    end
                end
                if (n == 0) begin
                    r      = '0;
                    r.kind = KIND_NONE;
                    r.last = 1'b1;
                    sched_results.push_back(r);
                end else begin
                    r      = sched_results.pop_back();
                    r.last = 1'b1;
                    sched_results.push_back(r);
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the beat until accepted
        end else begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                s_valid <= 1'b0;
                in_gap--;
            end else if (pending_items.size() != 0) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
                if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
                in_gap = draw_wait(tx_quiet);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_taken) begin
            rx_taken = 1'b0;
            if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
            rx_stall = draw_wait(rx_quiet);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && s_valid && s_ready) begin
            in_taken = 1'b1;
            sched_step(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            rx_taken = 1'b1;
            n_results++;
            if (sched_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result beat: kind=%0d slot=%0d task=%h full=%b last=%b",
                             m_data.kind, m_data.slot, m_data.task_out, m_data.table_full,
                             m_data.last);
                end
                fail_count++;
            end else begin
                want = sched_results.pop_front();
                if (m_data.kind !== want.kind || m_data.slot !== want.slot ||
                    m_data.task_out !== want.task_out ||
                    m_data.table_full !== want.table_full || m_data.last !== want.last) begin
                    if (fail_count < 10) begin
                        $display("mismatch: exp kind=%0d slot=%0d task=%h full=%b last=%b",
                                 want.kind, want.slot, want.task_out, want.table_full,
                                 want.last);
                        $display("          got kind=%0d slot=%0d task=%h full=%b last=%b",
                                 m_data.kind, m_data.slot, m_data.task_out,
                                 m_data.table_full, m_data.last);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int         rnd_count;
        int         perm_left;
        int         pick;
        logic [31:0] dly;
        logic [31:0] per;

        // directed: empty table, ignored code, field extremes
        pending_items.push_back(mk_item(FUNC_DISPATCH, 16'h0000, 32'h0, 32'h0));
        pending_items.push_back(mk_item(FUNC_TICK, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
        pending_items.push_back(mk_item(FUNC_UNUSED, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
        pending_items.push_back(mk_item(FUNC_ADD, 16'h0000, 32'h0, 32'h0));
        pending_items.push_back(mk_item(FUNC_ADD, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
        pending_items.push_back(mk_item(FUNC_ADD, 16'h1234, 32'h0, 32'h1));
        pending_items.push_back(mk_item(FUNC_ADD, 16'ha5a5, 32'h1, 32'h0));
        pending_items.push_back(mk_item(FUNC_DISPATCH, 16'h0, 32'h0, 32'h0));
        pending_items.push_back(mk_item(FUNC_TICK, 16'h0, 32'h0, 32'h0));
        pending_items.push_back(mk_item(FUNC_TICK, 16'h0, 32'h0, 32'h0));
        pending_items.push_back(mk_item(FUNC_DISPATCH, 16'h0, 32'h0, 32'h0));
        // fill the table, overflow it, then drain the one-shots
        for (int i = 0; i < 6; i++) begin
            pending_items.push_back(mk_item(FUNC_ADD, 16'($urandom), 32'h0, 32'h0));
        end
        pending_items.push_back(mk_item(FUNC_ADD, 16'h7777, 32'h5, 32'h3));
        pending_items.push_back(mk_item(FUNC_DISPATCH, 16'h0, 32'h0, 32'h0));
        // run count saturation
        pending_items.push_back(mk_item(FUNC_ADD, 16'h5a5a, 32'h0, 32'h0));
        for (int i = 0; i < 260; i++) begin
            pending_items.push_back(mk_item(FUNC_TICK, 16'($urandom), $urandom, $urandom));
        end
        pending_items.push_back(mk_item(FUNC_DISPATCH, 16'h0, 32'h0, 32'h0));
        pending_items.push_back(mk_item(FUNC_DISPATCH, 16'h0, 32'h0, 32'h0));

        // random: mostly one-shots with short delays, few permanent periodic slots
        rnd_count = 0;
        perm_left = 3;
        while (rnd_count < 45) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                pending_items.push_back(mk_item(FUNC_UNUSED, 16'($urandom), $urandom, $urandom));
            end else begin
                rnd_count++;
                if (pick < 42) begin
                    pick = $urandom_range(0, 99);
                    per  = 32'h0;
                    if (pick < 70) begin
                        dly = $urandom_range(0, 3);
                    end else if (pick < 92 || perm_left == 0) begin
                        dly = $urandom_range(4, 12);
                    end else begin
                        dly = $urandom;
                        per = $urandom;
                        perm_left--;
                    end
                    if (per == 0 && perm_left > 0 && $urandom_range(0, 7) == 0) begin
                        per = $urandom_range(1, 6);
                        perm_left--;
                    end
                    pending_items.push_back(mk_item(FUNC_ADD, 16'($urandom), dly, per));
                end else if (pick < 75) begin
                    pending_items.push_back(mk_item(FUNC_TICK, 16'($urandom), $urandom,
                                                    $urandom));
                end else begin
                    pending_items.push_back(mk_item(FUNC_DISPATCH, 16'($urandom), $urandom,
                                                    $urandom));
                end
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (sched_results.size() != 0) @(posedge aclk);
        repeat (4 * NUM_SLOTS + 16) @(posedge aclk);

        $display("beats: %0d add, %0d tick, %0d dispatch, %0d ignored; %0d results checked",
                 n_adds, n_ticks, n_dispatches, n_ignored, n_results);
        $display("table full acks %0d, tasks dispatched %0d, saturated run increments %0d",
                 n_full, n_tasks, n_saturated);
        if (fail_count == 0 && sched_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: cooperative_task_scheduler.f
+incdir+hw/rtl
hw/rtl/cts_pkg.sv
hw/rtl/cts_slot_ram.sv
hw/rtl/cts_out_buf.sv
hw/rtl/cts_engine.sv
hw/rtl/cooperative_task_scheduler.sv
tb/tb_cooperative_task_scheduler.sv
